// ----- design/b64d_pkg.sv -----
// shared types, constants and the character lookup of the base64 decoder
`default_nettype none
package b64d_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_PAD     = 8'h3D;

  localparam logic [7:0] LOWER_OFS  = 8'd71;  // 'a' maps to 26
  localparam logic [7:0] DIGIT_OFS  = 8'd4;   // '0' maps to 52
  localparam logic [5:0] VAL_PLUS   = 6'd62;
  localparam logic [5:0] VAL_SLASH  = 6'd63;

  // one unit of work handed from front to back
  typedef struct packed {
    logic        bad;
    logic [23:0] word;
  } job_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } char_val_t;

  function automatic char_val_t char_decode(input logic [7:0] c);
    char_val_t  r;
    logic [7:0] d;
    r = '{ok: 1'b0, val: 6'd0};
    d = 8'd0;
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      d = c - CH_UPPER_A;
      r = '{ok: 1'b1, val: d[5:0]};
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      d = c - LOWER_OFS;
      r = '{ok: 1'b1, val: d[5:0]};
    end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
      d = c + DIGIT_OFS;
      r = '{ok: 1'b1, val: d[5:0]};
    end else if (c == CH_PLUS) begin
      r = '{ok: 1'b1, val: VAL_PLUS};
    end else if (c == CH_SLASH) begin
      r = '{ok: 1'b1, val: VAL_SLASH};
    end else if (c == CH_PAD) begin
      r = '{ok: 1'b1, val: 6'd0};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- design/base64_stream_decoder.sv -----
// top level of the streaming base64 decoder
// ---------------------------------------------------------------------------
// input channel: in_valid/in_ready with code_char (ascii) and end_of_text.
// a transaction carries one character; end_of_text marks the last one.
// output channel: out_valid/out_ready with data_byte, last_of_run, bad_char.
// four characters give three bytes, most significant first; an unfinished
// group at end of text is padded with zero values and still gives three
// bytes. a character outside the alphabet gives one result with bad_char
// and last_of_run set, and further characters are dropped up to end of text.
// throughput: one character accepted per cycle while the job queue has
// room; output runs at one byte per cycle while out_ready is high, so a
// stream of full groups flows without stalls. a burst of end-of-text
// characters gives three bytes each and is paced by the back end
// serialiser at one byte per cycle. the job of a group passes through the
// job queue and the back end output register before its first byte shows.
// reset (rst, synchronous): empties the job queue and output register and
// clears the partial group. when the receiver stalls, the four-entry job
// queue fills and in_ready drops until space frees up.
// ---------------------------------------------------------------------------
`default_nettype none
module base64_stream_decoder
  import b64d_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] code_char,
  input  wire logic       end_of_text,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      data_byte,
  output logic            last_of_run,
  output logic            bad_char
);

  // front to queue
  logic fq_valid, fq_ready;
  job_t fq_job;
  // queue to back
  logic qb_valid, qb_ready;
  job_t qb_job;

  // classification and group collection
  b64d_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .code_char   (code_char),
    .end_of_text (end_of_text),
    .job_valid   (fq_valid),
    .job         (fq_job),
    .job_ready   (fq_ready)
  );

  // decouples the character side from the byte side
  b64d_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_job   (fq_job),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_job    (qb_job)
  );

  // byte serialiser with registered output
  b64d_back u_back (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (qb_valid),
    .job_ready   (qb_ready),
    .job         (qb_job),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .data_byte   (data_byte),
    .last_of_run (last_of_run),
    .bad_char    (bad_char)
  );

endmodule
`default_nettype wire

// ----- design/b64d_front.sv -----
// front end: classifies characters, collects groups and issues jobs
`default_nettype none
module b64d_front
  import b64d_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] code_char,
  input  wire logic       end_of_text,
  output logic            job_valid,
  output job_t            job,
  input  wire logic       job_ready
);

  logic [17:0] group_bits, group_bits_next;
  logic [1:0]  group_count, group_count_next;
  logic        discarding, discarding_next;
  logic        accept;
  char_val_t   cv;
  logic [17:0] shifted;

  assign in_ready = job_ready;
  assign accept   = in_valid && in_ready;
  assign cv       = char_decode(code_char);
  assign shifted  = {group_bits[11:0], cv.val};

  always_comb begin
    group_bits_next  = group_bits;
    group_count_next = group_count;
    discarding_next  = discarding;
    job_valid        = 1'b0;
    job              = '{bad: 1'b0, word: 24'd0};
    if (accept) begin
      if (discarding) begin
        if (end_of_text) begin
          discarding_next = 1'b0;
        end
      end else if (!cv.ok) begin
        group_bits_next  = 18'd0;
        group_count_next = 2'd0;
        discarding_next  = !end_of_text;
        job_valid        = 1'b1;
        job              = '{bad: 1'b1, word: 24'd0};
      end else if (group_count == 2'd3) begin
        group_bits_next  = 18'd0;
        group_count_next = 2'd0;
        job_valid        = 1'b1;
        job              = '{bad: 1'b0, word: {group_bits, cv.val}};
      end else if (end_of_text) begin
        // short final group, padded with zero values
        group_bits_next  = 18'd0;
        group_count_next = 2'd0;
        job_valid        = 1'b1;
        case (group_count)
          2'd0:    job.word = {shifted[5:0], 18'd0};
          2'd1:    job.word = {shifted[11:0], 12'd0};
          default: job.word = {shifted, 6'd0};
        endcase
      end else begin
        group_bits_next  = shifted;
        group_count_next = group_count + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_bits  <= 18'd0;
      group_count <= 2'd0;
      discarding  <= 1'b0;
    end else begin
      group_bits  <= group_bits_next;
      group_count <= group_count_next;
      discarding  <= discarding_next;
    end
  end

  a_discard_no_job: assert property (@(posedge clk) disable iff (rst)
    discarding |-> !job_valid)
    else $error("job issued while discarding");

  a_bad_clears_group: assert property (@(posedge clk) disable iff (rst)
    job_valid && job.bad |=> group_count == 2'd0)
    else $error("group kept after invalid character");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    accept && end_of_text |=> group_count == 2'd0 && !discarding)
    else $error("state not cleared at end of text");

endmodule
`default_nettype wire

// ----- design/b64d_queue.sv -----
// short job queue between front and back
`default_nettype none
module b64d_queue
  import b64d_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push_valid,
  output logic      push_ready,
  input  wire job_t push_job,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output job_t      pop_job
);

  job_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push, pop;

  assign push_ready = count != QCNT_W'(QDEPTH);
  assign pop_valid  = count != '0;
  assign pop_job    = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("queue overfilled");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    count != QCNT_W'(QDEPTH) && count != '0 |-> wr_ptr != rd_ptr)
    else $error("pointers disagree with count");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    count == '0 |-> wr_ptr == rd_ptr)
    else $error("empty queue with pointer gap");

endmodule
`default_nettype wire

// ----- design/b64d_back.sv -----
// back end: turns jobs into byte results through an output register
`default_nettype none
module b64d_back
  import b64d_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       job_valid,
  output logic            job_ready,
  input  wire job_t       job,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      data_byte,
  output logic            last_of_run,
  output logic            bad_char
);

  logic [15:0] rest;      // bytes still to show from the current word
  logic [1:0]  left;      // how many of them
  logic        advance;

  assign advance   = !out_valid || out_ready;
  assign job_ready = advance && left == 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      left      <= 2'd0;
    end else if (advance) begin
      if (left != 2'd0) begin
        out_valid <= 1'b1;
        left      <= left - 2'd1;
      end else if (job_valid) begin
        out_valid <= 1'b1;
        left      <= job.bad ? 2'd0 : 2'd2;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (left != 2'd0) begin
        data_byte   <= rest[15:8];
        rest        <= {rest[7:0], 8'd0};
        last_of_run <= left == 2'd1;
        bad_char    <= 1'b0;
      end else if (job_valid) begin
        data_byte   <= job.bad ? 8'd0 : job.word[23:16];
        rest        <= job.word[15:0];
        last_of_run <= job.bad;
        bad_char    <= job.bad;
      end
    end
  end

  a_bad_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_char |-> last_of_run && data_byte == 8'd0)
    else $error("error result malformed");

  a_mid_word_shown: assert property (@(posedge clk) disable iff (rst)
    left != 2'd0 |-> out_valid && !last_of_run && !bad_char)
    else $error("word bytes out of step");

  a_no_pop_mid_word: assert property (@(posedge clk) disable iff (rst)
    left != 2'd0 |-> !job_ready)
    else $error("job taken while a word is in flight");

endmodule
`default_nettype wire

// ----- tb/base64_stream_decoder_tb.sv -----
// self-checking testbench for the streaming base64 decoder
module base64_stream_decoder_tb;
  import b64d_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int TAIL_CYCLES  = 20;      // quiet time after the last byte
  localparam int RANDOM_ITEMS = 235;
  localparam int HOLD_AT      = 60;      // characters taken before the long back-pressure
  localparam int HOLD_CYCLES  = 120;

  // one character waiting to be offered, with its lead-in idle time
  typedef struct {
    logic [7:0] ch;
    logic       eot;
    int         gap;
    bit         drain;  // wait for every decoded byte before offering
  } char_item_t;

  // one decoded byte as the block should present it
  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       bad;
  } dec_byte_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic [7:0] code_char = 8'h00;
  logic       end_of_text = 1'b0;
  logic       out_ready = 1'b0;
  wire        in_ready;
  wire        out_valid;
  wire  [7:0] data_byte;
  wire        last_of_run;
  wire        bad_char;

  char_item_t char_feed[$];   // characters still to be sent
  dec_byte_t  bytes_due[$];   // decoded bytes not yet seen on the output

  // decoder state as the stream has left it so far
  logic [17:0] acc_bits = '0;
  logic [1:0]  acc_cnt = '0;
  logic        skipping = 1'b0;

  int mismatch_count = 0;
  int accepted_items = 0;
  int cycle_count = 0;

  // driver and receiver bookkeeping
  int  idle_left = 0;
  bit  gap_loaded = 1'b0;
  int  stall_left = 0;
  int  calm_left = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  wire long_hold = (hold_left != 0);

  base64_stream_decoder u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .code_char  (code_char),
    .end_of_text(end_of_text),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .data_byte  (data_byte),
    .last_of_run(last_of_run),
    .bad_char   (bad_char)
  );

  always #10 clk = ~clk;

  always @(posedge clk) cycle_count++;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // {ok, six-bit value} of one character; pad counts as value zero
  function automatic logic [6:0] char_value(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      d = c - CH_UPPER_A;
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      d = c - CH_LOWER_A + 8'd26;
    end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
      d = c - CH_DIGIT_0 + 8'd52;
    end else if (c == CH_PLUS) begin
      d = 8'd62;
    end else if (c == CH_SLASH) begin
      d = 8'd63;
    end else if (c != CH_PAD) begin
      return 7'h00;
    end
    return {1'b1, d[5:0]};
  endfunction

  // three bytes of a group, most significant first, last flag on the third
  function automatic void push_group(input logic [23:0] word);
    bytes_due.push_back(dec_byte_t'{word[23:16], 1'b0, 1'b0});
    bytes_due.push_back(dec_byte_t'{word[15:8], 1'b0, 1'b0});
    bytes_due.push_back(dec_byte_t'{word[7:0], 1'b1, 1'b0});
  endfunction

  // advance the decoder by one accepted character and queue what it gives
  function automatic void decode_step(input logic [7:0] c, input logic eot);
    logic [6:0]  cv;
    logic [23:0] word;
    if (skipping) begin
      // dropped until end of text, which brings back the reset state
      if (eot) skipping = 1'b0;
      return;
    end
    cv = char_value(c);
    if (!cv[6]) begin
      // partial group thrown away, single error byte
      acc_bits = '0;
      acc_cnt  = '0;
      skipping = !eot;
      bytes_due.push_back(dec_byte_t'{8'h00, 1'b1, 1'b1});
      return;
    end
    if (acc_cnt == 2'd3) begin
      // fourth value closes the group, end of text adds nothing more
      word = {acc_bits, cv[5:0]};
      acc_bits = '0;
      acc_cnt  = '0;
      push_group(word);
      return;
    end
    acc_bits = {acc_bits[11:0], cv[5:0]};
    acc_cnt  = acc_cnt + 2'd1;
    if (eot) begin
      // unfinished group padded out with zero values
      word = {acc_bits, 6'd0} << (6 * (3 - acc_cnt));
      acc_bits = '0;
      acc_cnt  = '0;
      push_group(word);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // idle stretch: mostly short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 92) return $urandom_range(3, 6);
    return $urandom_range(10, 30);
  endfunction

  function automatic void add_char(input logic [7:0] ch, input logic eot, input bit calm,
                                   input bit drain);
    char_item_t it;
    it.ch    = ch;
    it.eot   = eot;
    it.gap   = (calm || $urandom_range(0, 1) == 0) ? 0 : idle_len();
    it.drain = drain;
    char_feed.push_back(it);
  endfunction

  function automatic void add_text(input string s, input bit eot_last);
    for (int i = 0; i < s.len(); i++) add_char(s[i], eot_last && i == s.len() - 1, 1'b0, 1'b0);
  endfunction

  // any character of the alphabet, pad included
  function automatic logic [7:0] pick_b64();
    int k;
    k = $urandom_range(0, 64);
    if (k < 26) return 8'(CH_UPPER_A + k);
    if (k < 52) return 8'(CH_LOWER_A + k - 26);
    if (k < 62) return 8'(CH_DIGIT_0 + k - 52);
    if (k == 62) return CH_PLUS;
    if (k == 63) return CH_SLASH;
    return CH_PAD;
  endfunction

  function automatic logic [7:0] pick_bad();
    logic [7:0] c;
    logic [6:0] cv;
    do begin
      c  = 8'($urandom_range(0, 255));
      cv = char_value(c);
    end while (cv[6]);
    return c;
  endfunction

  function automatic void note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endfunction

  // ---------------------------------------------------------------------------
  // sender: offers the head of the feed, holds it until the transaction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid    <= 1'b0;
      code_char   <= 8'h00;
      end_of_text <= 1'b0;
      idle_left   = 0;
      gap_loaded  = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        decode_step(code_char, end_of_text);
        void'(char_feed.pop_front());
        accepted_items++;
        gap_loaded = 1'b0;
      end
      // free to choose the next offer only when nothing is pending
      if (!in_valid || in_ready) begin
        if (char_feed.size() != 0 && !gap_loaded) begin
          // during the long back-pressure keep pushing so the queue fills
          idle_left  = long_hold ? 0 : char_feed[0].gap;
          gap_loaded = 1'b1;
        end
        if (char_feed.size() == 0) begin
          in_valid <= 1'b0;
        end else if (idle_left > 0) begin
          idle_left--;
          in_valid <= 1'b0;
        end else if (char_feed[0].drain && bytes_due.size() != 0) begin
          in_valid <= 1'b0;
        end else begin
          in_valid    <= 1'b1;
          code_char   <= char_feed[0].ch;
          end_of_text <= char_feed[0].eot;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: one long hold-off once enough characters have gone in
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && accepted_items >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver: random stalls, with calm stretches of full throughput
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left = 0;
      calm_left  = 0;
    end else begin
      if (calm_left > 0) calm_left--;
      else if ($urandom_range(0, 199) == 0) calm_left = 60;
      if (long_hold) begin
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (calm_left == 0 && $urandom_range(0, 99) < 25) begin
        stall_left = idle_len() - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // check every output transaction against the oldest byte due
  always @(posedge clk) begin
    dec_byte_t want;
    if (!rst && out_valid && out_ready) begin
      if (bytes_due.size() == 0) begin
        note_failure($sformatf("unexpected byte %02h last %0b bad %0b",
                               data_byte, last_of_run, bad_char));
      end else begin
        want = bytes_due.pop_front();
        if (data_byte !== want.data || last_of_run !== want.last || bad_char !== want.bad)
          note_failure($sformatf("mismatch: got byte %02h last %0b bad %0b, want %02h %0b %0b",
                                 data_byte, last_of_run, bad_char,
                                 want.data, want.last, want.bad));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int  budget;
    int  kind;
    int  len;
    int  pre;
    bit  calm;
    bit  drain;
    bit  eot;
    bit  timed_out;
    logic [7:0] ch;

    budget = 0;

    // directed: full group ending the text
    add_text("TWFu", 1'b1);
    // pad characters inside a full group
    add_text("QQ==", 1'b1);
    // three values then end of text, padded out
    add_text("QUI", 1'b1);
    // single value at the top of the range, padded out
    add_text("/", 1'b1);
    // partial group lost to a bad code, then dropped characters until the end mark
    add_char(CH_PLUS, 1'b0, 1'b0, 1'b0);
    add_char(8'hFF, 1'b0, 1'b0, 1'b0);
    add_char(CH_UPPER_A, 1'b0, 1'b0, 1'b0);
    add_char(8'h00, 1'b1, 1'b0, 1'b0);
    // high-half code carrying end of text, nothing dropped after it
    add_char(8'h80, 1'b1, 1'b0, 1'b0);
    // bad code just past the lower-case range, together with end of text
    add_text("z9", 1'b0);
    add_char(8'h7B, 1'b1, 1'b0, 1'b0);
    // range ends of the letter and digit classes: Z, a, z and 0
    add_text("Zaz0", 1'b1);

    // random texts until the budget of useful characters is spent
    while (budget < RANDOM_ITEMS) begin
      kind  = $urandom_range(0, 9);
      calm  = ($urandom_range(0, 3) == 0);
      drain = (budget == 0) || ($urandom_range(0, 19) == 0);
      if (kind < 7) begin
        // well-formed text, occasionally a long one
        len = 4 * (($urandom_range(0, 9) == 0) ? 12 : $urandom_range(0, 4))
              + $urandom_range(0, 3);
        if (len == 0) len = 1;
        for (int i = 0; i < len; i++) begin
          ch = pick_b64();
          // pad now and then in one of the last two places
          if (len > 2 && i >= len - 2 && $urandom_range(0, 2) == 0) ch = CH_PAD;
          add_char(ch, i == len - 1, calm, drain && i == 0);
        end
        budget += len;
      end else if (kind < 9) begin
        // valid prefix, bad code, and junk to throw away if the text goes on
        pre = $urandom_range(0, 6);
        for (int i = 0; i < pre; i++) add_char(pick_b64(), 1'b0, calm, drain && i == 0);
        eot = ($urandom_range(0, 3) == 0);
        add_char(pick_bad(), eot, calm, drain && pre == 0);
        budget += pre + 1;
        if (!eot) begin
          len = $urandom_range(0, 4);
          for (int i = 0; i < len; i++)
            add_char(8'($urandom_range(0, 255)), 1'b0, calm, 1'b0);
          add_char(8'($urandom_range(0, 255)), 1'b1, calm, 1'b0);
        end
      end else begin
        // raw noise with end marks scattered through it
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
          add_char(8'($urandom_range(0, 255)), (i == len - 1) || ($urandom_range(0, 2) == 0),
                   calm, drain && i == 0);
        budget += len;
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while ((char_feed.size() != 0 || in_valid || bytes_due.size() != 0) &&
           cycle_count < CYCLE_LIMIT)
      @(posedge clk);
    timed_out = (cycle_count >= CYCLE_LIMIT);

    // let anything stray come out so the monitor can flag it
    if (!timed_out) repeat (TAIL_CYCLES) @(posedge clk);
    if (bytes_due.size() != 0)
      note_failure($sformatf("%0d decoded bytes never arrived", bytes_due.size()));

    if (!timed_out && mismatch_count == 0)
      $display("base64_stream_decoder_tb: done, clean");
    else
      $display("base64_stream_decoder_tb: done, errors");
    $finish;
  end

endmodule

// ----- sim.f -----
design/b64d_pkg.sv
design/b64d_front.sv
design/b64d_queue.sv
design/b64d_back.sv
design/base64_stream_decoder.sv
tb/base64_stream_decoder_tb.sv
